@@ hw/rtl/qdd_pkg.sv @@
// Shared types, constants and the transition lookup for the quadrature detent decoder.
package qdd_pkg;

    localparam int COUNT_WIDTH = 16;   // pulse counter width, 8 to 32
    localparam int PULSE_W     = 16;   // width of the reported pulse count
    localparam int PPD_W       = 7;    // pulses-per-detent register width

    localparam logic [PPD_W-1:0] PPD_RESET = PPD_W'(4);

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TAKE   = 2'd1,
        CMD_INIT   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STEP_NONE  = 2'd0,
        STEP_PLUS  = 2'd1,
        STEP_MINUS = 2'd2
    } t_step;

    typedef enum logic [1:0] {
        DET_NONE = 2'd0,
        DET_CCW  = 2'd1,
        DET_CW   = 2'd2
    } t_detent;

    typedef struct packed {
        t_cmd cmd;
        logic pin_a;
        logic pin_b;
    } t_word;

    typedef struct packed {
        t_detent            detent;
        t_step              step;
        logic [PULSE_W-1:0] pulse_count;
    } t_result;

    // Transition code is {previous A, previous B, current A, current B}.
    function automatic t_step f_step_lookup(input logic [3:0] code);
        t_step s;
        case (code) inside
            4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_PLUS;
            4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_MINUS;
            default:                            s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/qdd_core.sv @@
// Decoder state and the single-pass update for one command word.
module qdd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  qdd_pkg::t_word              i_word,
    input  logic [qdd_pkg::PPD_W-1:0]   i_ppd,
    output qdd_pkg::t_result            o_result
);
    import qdd_pkg::*;

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic [1:0]                     r_levels, n_levels;
    t_step                          r_dir, n_dir;
    logic signed [COUNT_WIDTH-1:0]  r_count, n_count;

    logic [1:0]                     levels;
    t_step                          step;
    t_detent                        detent;
    logic signed [COUNT_WIDTH-1:0]  base;
    logic signed [COUNT_WIDTH:0]    ppd_x;
    logic signed [COUNT_WIDTH:0]    count_x;

    assign levels  = {i_word.pin_a, i_word.pin_b};
    // zero detent size acts as one
    assign ppd_x   = (i_ppd == '0) ? (COUNT_WIDTH+1)'(1)
                                   : $signed({{(COUNT_WIDTH+1-PPD_W){1'b0}}, i_ppd});
    assign count_x = {r_count[COUNT_WIDTH-1], r_count};

    always_comb begin
        n_levels = r_levels;
        n_dir    = r_dir;
        n_count  = r_count;
        step     = STEP_NONE;
        detent   = DET_NONE;
        base     = r_count;
        case (i_word.cmd)
            CMD_SAMPLE: begin
                step     = f_step_lookup({r_levels, levels});
                n_levels = levels;
                if (step != STEP_NONE) begin
                    // reversal restarts the count
                    if (r_dir != STEP_NONE && r_dir != step) begin
                        base = '0;
                    end
                    n_dir = step;
                    if (step == STEP_PLUS) begin
                        n_count = (base != CNT_MAX) ? base + COUNT_WIDTH'(1) : base;
                    end else begin
                        n_count = (base != CNT_MIN) ? base - COUNT_WIDTH'(1) : base;
                    end
                end
            end
            CMD_TAKE: begin
                if (count_x >= ppd_x) begin
                    n_count = COUNT_WIDTH'(count_x - ppd_x);
                    detent  = DET_CCW;
                end else if (count_x <= -ppd_x) begin
                    n_count = COUNT_WIDTH'(count_x + ppd_x);
                    detent  = DET_CW;
                end
            end
            CMD_INIT: begin
                n_levels = levels;
            end
            default: ;
        endcase
    end

    assign o_result.detent      = detent;
    assign o_result.step        = step;
    assign o_result.pulse_count = PULSE_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= '0;
            r_dir    <= STEP_NONE;
            r_count  <= '0;
        end else if (i_advance) begin
            r_levels <= n_levels;
            r_dir    <= n_dir;
            r_count  <= n_count;
        end
    end

    a_step_only_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.step != STEP_NONE) |-> i_word.cmd == CMD_SAMPLE)
        else $error("step reported for a non-sample word");

    a_detent_only_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.detent != DET_NONE) |-> i_word.cmd == CMD_TAKE)
        else $error("detent reported for a non-take word");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_count) && $stable(r_dir) && $stable(r_levels)))
        else $error("state moved without an advancing word");

    a_init_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_word.cmd == CMD_INIT) |=> ($stable(r_count) && $stable(r_dir)))
        else $error("capture word altered count or direction");

endmodule

@@ hw/rtl/quadrature_detent_decoder.sv @@
// Top level: input register, decoder core, output register and detent-size register.
// Path: an accepted word passes the input register and then the result register, which
//   presents its result word on o_valid.
// Throughput: one word per cycle while i_ready holds; the core's single lookup-and-add sets this figure.
// Reset (synchronous, i_rst_n low): levels, direction and count clear, detent size 4,
//   both registers empty.
module quadrature_detent_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command word in
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_command,
    input  logic                        i_pin_a,
    input  logic                        i_pin_b,
    // result word out
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_detent,
    output logic [1:0]                  o_step,
    output logic signed [qdd_pkg::PULSE_W-1:0] o_pulse_count,
    // detent size register
    input  logic                        i_cfg_wr_en,
    input  logic [qdd_pkg::PPD_W-1:0]   i_cfg_wr_data
);
    import qdd_pkg::*;

    logic               r_in_valid;
    t_word              r_in_word;
    logic               r_out_valid;
    t_result            r_out;
    logic [PPD_W-1:0]   r_ppd;

    logic               out_free;   // result register can take a word this cycle
    logic               advance;    // registered input word moves into the result register
    t_result            result;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    // input register refills as it drains, so no bubble at full rate
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppd <= PPD_RESET;
        end else if (i_cfg_wr_en) begin
            r_ppd <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_word.cmd   <= t_cmd'(i_command);
            r_in_word.pin_a <= i_pin_a;
            r_in_word.pin_b <= i_pin_b;
        end
    end

    qdd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in_word),
        .i_ppd     (r_ppd),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_detent      = r_out.detent;
    assign o_step        = r_out.step;
    assign o_pulse_count = r_out.pulse_count;

endmodule
